// ===== hdl/tstl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the touch swipe/tap level control block.
package tstl_pkg;

  // Coordinate and field widths
  localparam int COORD_BITS     = 12;
  localparam int RATIO_BITS     = 8;
  localparam int STEP_BITS      = 8;
  localparam int TAP_TIME_BITS  = 16;
  localparam int LEVEL_BITS     = 7;
  localparam int HW_BITS        = 8;
  localparam int TIME_BITS      = 32;
  localparam int FINGER_BITS    = 4;
  localparam int ALU_BITS       = 32;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SWIPE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIR_RATIO = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_TIME  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BRI_FLOOR = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BRI_CEIL  = 3'd5;

  // Configuration reset values
  localparam logic [COORD_BITS-1:0]    RST_MIN_SWIPE = 12'd20;
  localparam logic [RATIO_BITS-1:0]    RST_DIR_RATIO = 8'd24;
  localparam logic [STEP_BITS-1:0]     RST_STEP      = 8'd10;
  localparam logic [TAP_TIME_BITS-1:0] RST_TAP_TIME  = 16'd200;
  localparam logic [LEVEL_BITS-1:0]    RST_BRI_FLOOR = 7'd5;
  localparam logic [LEVEL_BITS-1:0]    RST_BRI_CEIL  = 7'd100;

  // Level constants
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 7'd100;
  localparam logic [LEVEL_BITS-1:0] VOL_RESET = 7'd50;
  localparam logic [LEVEL_BITS-1:0] BRI_RESET = 7'd100;

  // Gesture modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_TRACK = 2'd1;
  localparam logic [1:0] MODE_VERT  = 2'd2;
  localparam logic [1:0] MODE_HORZ  = 2'd3;

  // Shared unit operations
  localparam logic OP_SUB = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0]    min_swipe_distance;
    logic [RATIO_BITS-1:0]    direction_ratio_q4;
    logic [STEP_BITS-1:0]     step_pixels;
    logic [TAP_TIME_BITS-1:0] max_tap_time;
    logic [LEVEL_BITS-1:0]    brightness_floor;
    logic [LEVEL_BITS-1:0]    brightness_ceiling;
  } cfg_t;

  typedef struct packed {
    logic                op;
    logic [ALU_BITS-1:0] a;
    logic [ALU_BITS-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                  tap;
    logic [1:0]            mode;
    logic [LEVEL_BITS-1:0] volume_level;
    logic [HW_BITS-1:0]    hw_volume;
    logic                  volume_changed;
    logic [LEVEL_BITS-1:0] brightness_level;
    logic                  brightness_changed;
  } result_t;

endpackage

// ===== hdl/tstl_in_if.sv =====
`timescale 1ns / 1ps
// Touch poll channel: valid/ready handshake with the poll payload.
interface tstl_in_if;
  import tstl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FINGER_BITS-1:0] finger_count;
  logic [COORD_BITS-1:0]  touch_x;
  logic [COORD_BITS-1:0]  touch_y;
  logic [TIME_BITS-1:0]   now_ms;

  modport source (output valid, finger_count, touch_x, touch_y, now_ms, input ready);
  modport sink   (input valid, finger_count, touch_x, touch_y, now_ms, output ready);
endinterface

// ===== hdl/tstl_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with levels, mode and change flags.
interface tstl_out_if;
  import tstl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  tap;
  logic [1:0]            mode;
  logic [LEVEL_BITS-1:0] volume_level;
  logic [HW_BITS-1:0]    hw_volume;
  logic                  volume_changed;
  logic [LEVEL_BITS-1:0] brightness_level;
  logic                  brightness_changed;

  modport source (output valid, tap, mode, volume_level, hw_volume, volume_changed,
                  brightness_level, brightness_changed, input ready);
  modport sink   (input valid, tap, mode, volume_level, hw_volume, volume_changed,
                  brightness_level, brightness_changed, output ready);
endinterface

// ===== hdl/touch_swipe_tap_level_control.sv =====
`timescale 1ns / 1ps
// Top level: config registers, sequencer, shared unit and output register.
//
// Usage:
//   in_ch carries one touch poll per beat (finger count, x, y, ms time).
//   out_ch carries one result beat per poll: tap, mode after the poll,
//   volume and brightness percent, hardware volume 0..255, change flags.
//   cfg_wr_en/cfg_index/cfg_data write a config register;
//   write only while no poll is in flight. Unknown indexes are ignored.
// Timing:
//   A poll goes through one shared subtract/multiply unit under a small
//   sequencer: two subtracts, two ratio multiplies while tracking, one
//   update step and a hand-off to the output register. The result shows
//   on out_ch in the same cycle that in_ch.ready rises again, so a new
//   poll is taken only once the last one has left the sequencer.
// Reset (rst, synchronous): mode idle, volume 50, brightness 100, config
//   registers to their defaults, output register empty.
// Stall: a result waits in the output register; the next poll is taken
//   and worked on, then held in the final step until out_ch frees.
module touch_swipe_tap_level_control (
  input  logic                                 clk,
  input  logic                                 rst,
  tstl_in_if.sink                              in_ch,
  tstl_out_if.source                           out_ch,
  input  logic                                 cfg_wr_en,
  input  logic [tstl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tstl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import tstl_pkg::*;

  cfg_t                cfg;
  alu_req_t            alu_req;
  logic [ALU_BITS-1:0] alu_res;
  logic                ctrl_ready;
  logic                done;
  logic                out_free;
  logic                out_valid;
  result_t             res;
  result_t             out_q;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_swipe_distance <= RST_MIN_SWIPE;
      cfg.direction_ratio_q4 <= RST_DIR_RATIO;
      cfg.step_pixels        <= RST_STEP;
      cfg.max_tap_time       <= RST_TAP_TIME;
      cfg.brightness_floor   <= RST_BRI_FLOOR;
      cfg.brightness_ceiling <= RST_BRI_CEIL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_SWIPE: cfg.min_swipe_distance <= cfg_data[COORD_BITS-1:0];
        CFG_DIR_RATIO: cfg.direction_ratio_q4 <= cfg_data[RATIO_BITS-1:0];
        CFG_STEP:      cfg.step_pixels        <= cfg_data[STEP_BITS-1:0];
        CFG_TAP_TIME:  cfg.max_tap_time       <= cfg_data[TAP_TIME_BITS-1:0];
        CFG_BRI_FLOOR: cfg.brightness_floor   <= cfg_data[LEVEL_BITS-1:0];
        CFG_BRI_CEIL:  cfg.brightness_ceiling <= cfg_data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  tstl_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  tstl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (in_ch.valid),
    .finger_count (in_ch.finger_count),
    .touch_x      (in_ch.touch_x),
    .touch_y      (in_ch.touch_y),
    .now_ms       (in_ch.now_ms),
    .ready        (ctrl_ready),
    .alu_req      (alu_req),
    .alu_res      (alu_res),
    .out_free     (out_free),
    .done         (done),
    .res          (res)
  );

  assign in_ch.ready = ctrl_ready;
  assign out_free    = !out_valid || out_ch.ready;

  // Output register: parts the sequencer from a stalled receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_q <= res;
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.tap                = out_q.tap;
  assign out_ch.mode               = out_q.mode;
  assign out_ch.volume_level       = out_q.volume_level;
  assign out_ch.hw_volume          = out_q.hw_volume;
  assign out_ch.volume_changed     = out_q.volume_changed;
  assign out_ch.brightness_level   = out_q.brightness_level;
  assign out_ch.brightness_changed = out_q.brightness_changed;

  // Only a vertical swipe moves volume, only a horizontal one brightness
  a_vol_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.volume_changed |-> out_q.mode == MODE_VERT)
    else $error("volume changed outside a vertical swipe");

  a_bri_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.brightness_changed |-> out_q.mode == MODE_HORZ)
    else $error("brightness changed outside a horizontal swipe");

  // A tap always ends the gesture
  a_tap_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.tap |-> out_q.mode == MODE_IDLE)
    else $error("tap reported with gesture still active");

  // Sequencer is busy right after taking a poll
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("poll accepted while previous poll in flight");
endmodule

// ===== hdl/tstl_alu.sv =====
`timescale 1ns / 1ps
// Shared arithmetic unit: 32-bit subtract or ratio-by-coordinate multiply.
module tstl_alu (
  input  tstl_pkg::alu_req_t          req,
  output logic [tstl_pkg::ALU_BITS-1:0] res
);
  import tstl_pkg::*;

  logic [RATIO_BITS+COORD_BITS-1:0] prod;

  always_comb begin
    prod = req.a[RATIO_BITS-1:0] * req.b[COORD_BITS-1:0];
    case (req.op)
      OP_SUB:  res = req.a - req.b;
      OP_MUL:  res = ALU_BITS'(prod);
      default: res = '0;
    endcase
  end
endmodule

// ===== hdl/tstl_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer and gesture state: drives the shared unit, updates levels and mode.
module tstl_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  tstl_pkg::cfg_t                    cfg,
  input  logic                              start,
  input  logic [tstl_pkg::FINGER_BITS-1:0]  finger_count,
  input  logic [tstl_pkg::COORD_BITS-1:0]   touch_x,
  input  logic [tstl_pkg::COORD_BITS-1:0]   touch_y,
  input  logic [tstl_pkg::TIME_BITS-1:0]    now_ms,
  output logic                              ready,
  output tstl_pkg::alu_req_t                alu_req,
  input  logic [tstl_pkg::ALU_BITS-1:0]     alu_res,
  input  logic                              out_free,
  output logic                              done,
  output tstl_pkg::result_t                 res
);
  import tstl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DX   = 3'd1;
  localparam logic [2:0] S_DY   = 3'd2;
  localparam logic [2:0] S_MX   = 3'd3;
  localparam logic [2:0] S_MY   = 3'd4;
  localparam logic [2:0] S_ADJ  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // pct * 255 / 100 as a multiply by 2^19 * 2.55, exact for 0..100
  localparam logic [20:0] HW_RECIP = 21'd1336965;
  localparam int          HW_SHIFT = 19;
  localparam int          PROD_BITS = RATIO_BITS + COORD_BITS;

  function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS:0] v);
    logic [COORD_BITS:0] n;
    n = v[COORD_BITS] ? (~v + 1'b1) : v;
    return n[COORD_BITS-1:0];
  endfunction

  logic [2:0]             st;
  logic [1:0]             gmode;
  logic [COORD_BITS-1:0]  origin_x, origin_y, anchor_x, anchor_y;
  logic [TIME_BITS-1:0]   press_time;
  logic [LEVEL_BITS-1:0]  volume, brightness;
  logic                   tap, vol_chg, bri_chg;

  logic                   lift;
  logic [COORD_BITS-1:0]  x_in, y_in;
  logic [TIME_BITS-1:0]   now_in;
  logic [COORD_BITS:0]    dx, dy;
  logic                   tap_ok, vdom, hdom;

  logic [COORD_BITS-1:0]  adx, ady, pmag;
  logic [COORD_BITS-1:0]  ref_x, ref_y;
  logic [STEP_BITS-1:0]   step_eff;
  logic                   go_vert, go_hor, neg;
  logic [3:0]             pct_mag;
  logic [8:0]             pct_s, vsum, bsum, bfl;
  logic [LEVEL_BITS-1:0]  vol_new, bri_new;
  logic                   vol_upd, bri_upd;
  logic [27:0]            hw_full;
  logic [PROD_BITS-1:0]   prod;

  assign ready = (st == S_IDLE);
  assign done  = (st == S_FIN) && out_free;
  assign prod  = alu_res[PROD_BITS-1:0];

  // Reference points: the start point while tracking, the anchor on a swipe's own axis.
  assign ref_x = (gmode == MODE_HORZ) ? anchor_x : origin_x;
  assign ref_y = (gmode == MODE_VERT) ? anchor_y : origin_y;

  always_comb begin
    alu_req = '0;
    unique case (st)
      S_DX: begin
        alu_req.op = OP_SUB;
        alu_req.a  = lift ? now_in : ALU_BITS'(x_in);
        alu_req.b  = lift ? press_time : ALU_BITS'(ref_x);
      end
      S_DY: begin
        alu_req.op = OP_SUB;
        alu_req.a  = ALU_BITS'(ref_y);
        alu_req.b  = ALU_BITS'(y_in);
      end
      S_MX: begin
        alu_req.op = OP_MUL;
        alu_req.a  = ALU_BITS'(cfg.direction_ratio_q4);
        alu_req.b  = ALU_BITS'(mag(dx));
      end
      S_MY: begin
        alu_req.op = OP_MUL;
        alu_req.a  = ALU_BITS'(cfg.direction_ratio_q4);
        alu_req.b  = ALU_BITS'(mag(dy));
      end
      default: alu_req = '0;
    endcase
  end

  // Adjustment math for the update step
  always_comb begin
    adx      = mag(dx);
    ady      = mag(dy);
    step_eff = (cfg.step_pixels == '0) ? STEP_BITS'(1) : cfg.step_pixels;
    go_vert  = !lift && (((gmode == MODE_TRACK) && vdom) ||
               ((gmode == MODE_VERT) && (16'(ady) >= 16'(cfg.step_pixels))));
    go_hor   = !lift && (((gmode == MODE_TRACK) && !vdom && hdom) ||
               ((gmode == MODE_HORZ) && (16'(adx) >= 16'(cfg.step_pixels))));
    pmag     = go_vert ? ady : adx;
    neg      = go_vert ? dy[COORD_BITS] : dx[COORD_BITS];
    // truncated quotient times 5, held to 10: only 0, 1 or 2+ steps matter
    if (16'(pmag) < 16'(step_eff)) begin
      pct_mag = 4'd0;
    end else if (16'(pmag) < 16'({step_eff, 1'b0})) begin
      pct_mag = 4'd5;
    end else begin
      pct_mag = 4'd10;
    end
    pct_s = neg ? (9'd0 - 9'(pct_mag)) : 9'(pct_mag);

    vsum = 9'(volume) + pct_s;
    if (vsum[8]) begin
      vol_new = '0;
    end else if (vsum[7:0] > 8'(LEVEL_MAX)) begin
      vol_new = LEVEL_MAX;
    end else begin
      vol_new = vsum[LEVEL_BITS-1:0];
    end

    bsum = 9'(brightness) + pct_s;
    if ($signed(bsum) < $signed(9'(cfg.brightness_floor))) begin
      bfl = 9'(cfg.brightness_floor);
    end else begin
      bfl = bsum;
    end
    // ceiling applied last, wins when the bounds cross
    if ($signed(bfl) > $signed(9'(cfg.brightness_ceiling))) begin
      bri_new = cfg.brightness_ceiling;
    end else begin
      bri_new = bfl[LEVEL_BITS-1:0];
    end

    vol_upd = go_vert && (pct_mag != 4'd0);
    bri_upd = go_hor && (pct_mag != 4'd0);

    hw_full = 28'(volume) * 28'(HW_RECIP);
  end

  always_comb begin
    res.tap                = tap;
    res.mode               = gmode;
    res.volume_level       = volume;
    res.hw_volume          = (volume >= LEVEL_MAX) ? 8'hFF : hw_full[HW_SHIFT+HW_BITS-1:HW_SHIFT];
    res.volume_changed     = vol_chg;
    res.brightness_level   = brightness;
    res.brightness_changed = bri_chg;
  end

  // Sequencer and gesture state
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      gmode      <= MODE_IDLE;
      origin_x   <= '0;
      origin_y   <= '0;
      anchor_x   <= '0;
      anchor_y   <= '0;
      press_time <= '0;
      volume     <= VOL_RESET;
      brightness <= BRI_RESET;
    end else begin
      unique case (st)
        S_IDLE: if (start) st <= S_DX;
        S_DX:   st <= S_DY;
        S_DY:   st <= (!lift && (gmode == MODE_TRACK)) ? S_MX : S_ADJ;
        S_MX:   st <= S_MY;
        S_MY:   st <= S_ADJ;
        S_ADJ: begin
          st <= S_FIN;
          if (lift) begin
            gmode <= MODE_IDLE;
          end else if (gmode == MODE_IDLE) begin
            origin_x   <= x_in;
            origin_y   <= y_in;
            anchor_x   <= x_in;
            anchor_y   <= y_in;
            press_time <= now_in;
            gmode      <= MODE_TRACK;
          end else if (gmode == MODE_TRACK) begin
            if (go_vert) begin
              gmode <= MODE_VERT;
            end else if (go_hor) begin
              gmode <= MODE_HORZ;
            end
          end
          if (go_vert) anchor_y <= y_in;
          if (go_hor)  anchor_x <= x_in;
          if (vol_upd) volume <= vol_new;
          if (bri_upd) brightness <= bri_new;
        end
        S_FIN:  if (out_free) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (start && (st == S_IDLE)) begin
      lift   <= (finger_count == '0);
      x_in   <= touch_x;
      y_in   <= touch_y;
      now_in <= now_ms;
    end
    if (st == S_DX) begin
      dx     <= alu_res[COORD_BITS:0];
      tap_ok <= (alu_res[TIME_BITS-1:TAP_TIME_BITS] == '0) &&
                (alu_res[TAP_TIME_BITS-1:0] <= cfg.max_tap_time);
    end
    if (st == S_DY) dy <= alu_res[COORD_BITS:0];
    if (st == S_MX) begin
      vdom <= (ady >= cfg.min_swipe_distance) &&
              (PROD_BITS'({ady, 4'b0000}) >= prod);
    end
    if (st == S_MY) begin
      hdom <= (adx >= cfg.min_swipe_distance) &&
              (PROD_BITS'({adx, 4'b0000}) >= prod);
    end
    if (st == S_ADJ) begin
      // anchor equals origin while tracking, so only a zero distance blocks a tap
      tap     <= lift && (gmode == MODE_TRACK) && tap_ok && (cfg.min_swipe_distance != '0);
      vol_chg <= vol_upd && (vol_new != volume);
      bri_chg <= bri_upd && (bri_new != brightness);
    end
  end
endmodule

// ===== tb/sv/touch_swipe_tap_level_control_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the touch swipe/tap level control block.
module touch_swipe_tap_level_control_tb;
  import tstl_pkg::*;

  // Generous cycle budget; the run fails if it is used up.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 12;
  localparam int PHASES       = 9;
  localparam int PHASE_POLLS  = 172;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int HW_FULL      = 255;
  localparam int STEP_PCT     = 5;
  localparam int STEP_PCT_CAP = 10;

  // One directed poll; res holds a hand-typed result where typed is set.
  typedef struct packed {
    logic [FINGER_BITS-1:0] fingers;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [TIME_BITS-1:0]   t;
    logic                   typed;
    result_t                res;
  } poll_row_t;

  localparam result_t AT_REST  = '{1'b0, MODE_IDLE,  7'd50, 8'd127, 1'b0, 7'd100, 1'b0};
  localparam result_t PRESSED  = '{1'b0, MODE_TRACK, 7'd50, 8'd127, 1'b0, 7'd100, 1'b0};
  localparam result_t TAPPED   = '{1'b1, MODE_IDLE,  7'd50, 8'd127, 1'b0, 7'd100, 1'b0};
  localparam result_t PREDICT  = '0;

  // Directed polls at the reset config. First rows are typed in: idle lift,
  // tap right at the time limit, one ms over the limit, tap across the 32-bit
  // time wrap. Then a vertical swipe (entry, step, sub-step move, big reverse
  // move held to -10), a horizontal swipe that hits the ceiling and comes
  // back, an exact 45 degree move that dominates neither axis (tap on lift,
  // anchor still at origin), and a full-height swipe up.
  localparam int DIR_ROWS = 24;
  localparam poll_row_t DIRECTED [DIR_ROWS] = '{
    '{4'd0,  12'd0,    12'd0,    32'd0,           1'b1, AT_REST},
    '{4'd1,  12'd100,  12'd100,  32'd1000,        1'b1, PRESSED},
    '{4'd0,  12'd0,    12'd0,    32'd1200,        1'b1, TAPPED},
    '{4'd15, 12'd4095, 12'd4095, 32'd2000,        1'b1, PRESSED},
    '{4'd0,  12'd4095, 12'd4095, 32'd2201,        1'b1, AT_REST},
    '{4'd1,  12'd2000, 12'd2000, 32'hFFFF_FFFF,   1'b1, PRESSED},
    '{4'd0,  12'd2000, 12'd2000, 32'h0000_001F,   1'b1, TAPPED},
    '{4'd1,  12'd2000, 12'd2000, 32'd100,         1'b0, PREDICT},
    '{4'd1,  12'd2000, 12'd1900, 32'd110,         1'b0, PREDICT},
    '{4'd1,  12'd2000, 12'd1890, 32'd120,         1'b0, PREDICT},
    '{4'd1,  12'd2000, 12'd1895, 32'd130,         1'b0, PREDICT},
    '{4'd1,  12'd2000, 12'd3000, 32'd140,         1'b0, PREDICT},
    '{4'd0,  12'd2000, 12'd3000, 32'd150,         1'b0, PREDICT},
    '{4'd2,  12'd0,    12'd0,    32'd200,         1'b0, PREDICT},
    '{4'd2,  12'd4095, 12'd0,    32'd210,         1'b0, PREDICT},
    '{4'd2,  12'd0,    12'd0,    32'd220,         1'b0, PREDICT},
    '{4'd2,  12'd4090, 12'd0,    32'd230,         1'b0, PREDICT},
    '{4'd0,  12'd4090, 12'd0,    32'd240,         1'b0, PREDICT},
    '{4'd1,  12'd500,  12'd500,  32'd1000,        1'b0, PREDICT},
    '{4'd1,  12'd600,  12'd600,  32'd1010,        1'b0, PREDICT},
    '{4'd0,  12'd600,  12'd600,  32'd1100,        1'b0, PREDICT},
    '{4'd1,  12'd0,    12'd4095, 32'd2000,        1'b0, PREDICT},
    '{4'd1,  12'd0,    12'd0,    32'd2010,        1'b0, PREDICT},
    '{4'd0,  12'd0,    12'd0,    32'd2020,        1'b0, PREDICT}
  };

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  tstl_in_if  in_ch ();
  tstl_out_if out_ch ();

  touch_swipe_tap_level_control uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Gesture model state, mirrored at block widths.
  cfg_t                  cfg;
  logic [1:0]            g_mode;
  logic [COORD_BITS-1:0] org_x, org_y, anc_x, anc_y;
  logic [TIME_BITS-1:0]  press_at;
  logic [LEVEL_BITS-1:0] vol, bri;

  result_t     pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm;          // no idling on either side while set
  logic [31:0] clock_ms;      // running poll time for random gestures

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Gesture predictor
  // ---------------------------------------------------------------------
  function automatic int abs_i(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Percent change for a pixel move: whole steps times 5, held to +-10.
  // A zero step register acts as one pixel.
  function automatic int pct_step(input int px);
    int stp;
    int d;
    stp = (cfg.step_pixels == '0) ? 1 : int'(cfg.step_pixels);
    d = (px / stp) * STEP_PCT;   // truncates toward zero
    if (d > STEP_PCT_CAP) d = STEP_PCT_CAP;
    if (d < -STEP_PCT_CAP) d = -STEP_PCT_CAP;
    return d;
  endfunction

  function automatic bit nudge_volume(input int px);
    int d;
    int v;
    d = pct_step(px);
    if (d == 0) return 1'b0;
    v = int'(vol) + d;
    if (v < 0) v = 0;
    if (v > int'(LEVEL_MAX)) v = int'(LEVEL_MAX);
    if (v == int'(vol)) return 1'b0;
    vol = LEVEL_BITS'(v);
    return 1'b1;
  endfunction

  // Ceiling is applied after the floor, so it wins when the two cross.
  function automatic bit nudge_brightness(input int px);
    int d;
    int b;
    d = pct_step(px);
    if (d == 0) return 1'b0;
    b = int'(bri) + d;
    if (b < int'(cfg.brightness_floor)) b = int'(cfg.brightness_floor);
    if (b > int'(cfg.brightness_ceiling)) b = int'(cfg.brightness_ceiling);
    if (b == int'(bri)) return 1'b0;
    bri = LEVEL_BITS'(b);
    return 1'b1;
  endfunction

  // Advance the gesture state by one poll and return the result beat.
  function automatic result_t apply_poll(input logic [FINGER_BITS-1:0] f,
                                         input logic [COORD_BITS-1:0] px,
                                         input logic [COORD_BITS-1:0] py,
                                         input logic [TIME_BITS-1:0] t);
    result_t              r;
    int                   x, y, adx, ady, d, lim, ratio;
    logic [TIME_BITS-1:0] held;
    r = '0;
    x = int'(px);
    y = int'(py);
    lim = int'(cfg.min_swipe_distance);
    ratio = int'(cfg.direction_ratio_q4);
    if (f != '0) begin
      case (g_mode)
        MODE_IDLE: begin
          org_x = px;
          anc_x = px;
          org_y = py;
          anc_y = py;
          press_at = t;
          g_mode = MODE_TRACK;
        end
        MODE_TRACK: begin
          adx = abs_i(x - int'(org_x));
          ady = abs_i(y - int'(org_y));
          // vertical is tested first; smaller y is higher, so up is louder
          if (ady >= lim && ady * 16 >= ratio * adx) begin
            g_mode = MODE_VERT;
            r.volume_changed = nudge_volume(int'(org_y) - y);
            anc_y = py;
          end else if (adx >= lim && adx * 16 >= ratio * ady) begin
            g_mode = MODE_HORZ;
            r.brightness_changed = nudge_brightness(x - int'(org_x));
            anc_x = px;
          end
        end
        MODE_VERT: begin
          d = int'(anc_y) - y;
          if (abs_i(d) >= int'(cfg.step_pixels)) begin
            r.volume_changed = nudge_volume(d);
            anc_y = py;
          end
        end
        default: begin
          d = x - int'(anc_x);
          if (abs_i(d) >= int'(cfg.step_pixels)) begin
            r.brightness_changed = nudge_brightness(d);
            anc_x = px;
          end
        end
      endcase
    end else begin
      if (g_mode == MODE_TRACK) begin
        held = t - press_at;   // wraps modulo 2^32
        r.tap = (held <= TIME_BITS'(cfg.max_tap_time)) &&
                (abs_i(int'(anc_x) - int'(org_x)) < lim) &&
                (abs_i(int'(anc_y) - int'(org_y)) < lim);
      end
      g_mode = MODE_IDLE;
    end
    r.mode = g_mode;
    r.volume_level = vol;
    r.hw_volume = (vol >= LEVEL_MAX) ? HW_BITS'(HW_FULL) :
                  HW_BITS'((int'(vol) * HW_FULL) / int'(LEVEL_MAX));
    r.brightness_level = bri;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Poll sender
  // ---------------------------------------------------------------------
  // Valid only drops when a gap is drawn, so back-to-back beats never see
  // a low and a high scheduled in the same step.
  task automatic send_poll(input logic [FINGER_BITS-1:0] f,
                           input logic [COORD_BITS-1:0] x,
                           input logic [COORD_BITS-1:0] y,
                           input logic [TIME_BITS-1:0] t,
                           input logic typed,
                           input result_t typed_res);
    int      gap;
    result_t predicted;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.finger_count <= f;
    in_ch.touch_x      <= x;
    in_ch.touch_y      <= y;
    in_ch.now_ms       <= t;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // beat taken at this edge
    predicted = apply_poll(f, x, y, t);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // All six registers in one burst; write enable stays high throughout.
  task automatic program_regs(input cfg_t c);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MIN_SWIPE;
    cfg_data  <= CFG_DATA_BITS'(c.min_swipe_distance);
    @(posedge clk);
    cfg_index <= CFG_DIR_RATIO;
    cfg_data  <= CFG_DATA_BITS'(c.direction_ratio_q4);
    @(posedge clk);
    cfg_index <= CFG_STEP;
    cfg_data  <= CFG_DATA_BITS'(c.step_pixels);
    @(posedge clk);
    cfg_index <= CFG_TAP_TIME;
    cfg_data  <= CFG_DATA_BITS'(c.max_tap_time);
    @(posedge clk);
    cfg_index <= CFG_BRI_FLOOR;
    cfg_data  <= CFG_DATA_BITS'(c.brightness_floor);
    @(posedge clk);
    cfg_index <= CFG_BRI_CEIL;
    cfg_data  <= CFG_DATA_BITS'(c.brightness_ceiling);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg = c;
  endtask

  // Phase settings: low extremes, high extremes, zero step with crossed
  // brightness bounds, then random settings leaning toward small distances
  // so that swipes and taps both show up often.
  function automatic cfg_t phase_cfg(input int phase);
    cfg_t c;
    case (phase)
      1: c = '{12'd0, 8'd0, 8'd1, 16'd0, 7'd0, 7'd100};
      2: c = '{12'd4095, 8'd255, 8'd255, 16'd65535, 7'd100, 7'd100};
      3: c = '{12'd5, 8'd16, 8'd0, 16'd65535, 7'd80, 7'd20};
      default: begin
        c.min_swipe_distance = ($urandom_range(0, 3) == 0) ?
                               COORD_BITS'($urandom_range(0, COORD_MAX)) :
                               COORD_BITS'($urandom_range(0, 60));
        c.direction_ratio_q4 = RATIO_BITS'($urandom_range(0, 255));
        c.step_pixels = ($urandom_range(0, 3) == 0) ? STEP_BITS'($urandom_range(1, 255)) :
                        STEP_BITS'($urandom_range(1, 30));
        c.max_tap_time = ($urandom_range(0, 1) == 0) ? TAP_TIME_BITS'($urandom_range(0, 400)) :
                         TAP_TIME_BITS'($urandom_range(0, 65535));
        c.brightness_floor = LEVEL_BITS'($urandom_range(0, 100));
        c.brightness_ceiling = LEVEL_BITS'($urandom_range(0, 100));
      end
    endcase
    return c;
  endfunction

  function automatic logic [COORD_BITS-1:0] fit(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    return COORD_BITS'(v);
  endfunction

  // Random part: mostly press / moves / lift gestures with random content,
  // the rest noise polls with every field random. Now and then the sender
  // holds off until the block has nothing in flight.
  task automatic run_random(input int budget);
    int sent, moves, span, major, minor, axis, k, cx, cy, held;
    logic [31:0] t0;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 2) begin
        send_poll(FINGER_BITS'($urandom_range(0, 15)), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), $urandom, 1'b0, PREDICT);
        sent++;
      end else begin
        cx = $urandom_range(0, COORD_MAX);
        cy = $urandom_range(0, COORD_MAX);
        clock_ms = ($urandom_range(0, 7) == 0) ? $urandom : clock_ms + $urandom_range(1, 3000);
        t0 = clock_ms;
        send_poll(FINGER_BITS'($urandom_range(1, 15)), fit(cx), fit(cy), t0, 1'b0, PREDICT);
        moves = $urandom_range(0, 6);
        axis = $urandom_range(0, 2);
        span = int'(cfg.min_swipe_distance) + 3 * int'(cfg.step_pixels) + 30;
        if (span > COORD_MAX) span = COORD_MAX;
        for (k = 0; k < moves; k++) begin
          major = ($urandom_range(0, 15) == 0) ? COORD_MAX : $urandom_range(0, span);
          if ($urandom_range(0, 1) == 0) major = -major;
          minor = $urandom_range(0, abs_i(major) / 3);
          if ($urandom_range(0, 1) == 0) minor = -minor;
          case (axis)
            0: begin
              cy += major;
              cx += minor;
            end
            1: begin
              cx += major;
              cy += minor;
            end
            default: begin
              cx += major;
              cy += ($urandom_range(0, 1) == 0) ? major : -major;
            end
          endcase
          cx = int'(fit(cx));
          cy = int'(fit(cy));
          clock_ms += $urandom_range(0, 20);
          send_poll(FINGER_BITS'($urandom_range(1, 15)), fit(cx), fit(cy), clock_ms,
                    1'b0, PREDICT);
        end
        // lift: usually around the tap limit, sometimes wildly late
        case ($urandom_range(0, 3))
          0: held = $urandom_range(0, int'(cfg.max_tap_time));
          1: held = int'(cfg.max_tap_time) + $urandom_range(0, 2) - 1;
          2: held = $urandom_range(0, int'(cfg.max_tap_time) * 2 + 50);
          default: held = $urandom;
        endcase
        clock_ms = t0 + 32'(held);
        send_poll('0, COORD_BITS'($urandom), COORD_BITS'($urandom), clock_ms, 1'b0, PREDICT);
        sent += moves + 2;
      end
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  initial begin : result_side
    int      stall;
    result_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      // result beat taken at this edge
      if (pending_results.size() == 0) begin
        $error("result beat with no poll outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("tap", want.tap, out_ch.tap);
        check_field("mode", want.mode, out_ch.mode);
        check_field("volume_level", want.volume_level, out_ch.volume_level);
        check_field("hw_volume", want.hw_volume, out_ch.hw_volume);
        check_field("volume_changed", want.volume_changed, out_ch.volume_changed);
        check_field("brightness_level", want.brightness_level, out_ch.brightness_level);
        check_field("brightness_changed", want.brightness_changed,
                    out_ch.brightness_changed);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : poll_side
    int phase;
    int r;
    calm               = 1'b0;
    clock_ms           = 32'd5000;
    cfg                = '{RST_MIN_SWIPE, RST_DIR_RATIO, RST_STEP, RST_TAP_TIME,
                           RST_BRI_FLOOR, RST_BRI_CEIL};
    g_mode             = MODE_IDLE;
    org_x              = '0;
    org_y              = '0;
    anc_x              = '0;
    anc_y              = '0;
    press_at           = '0;
    vol                = VOL_RESET;
    bri                = BRI_RESET;
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.finger_count <= '0;
    in_ch.touch_x      <= '0;
    in_ch.touch_y      <= '0;
    in_ch.now_ms       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < DIR_ROWS; r++)
      send_poll(DIRECTED[r].fingers, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].t,
                DIRECTED[r].typed, DIRECTED[r].res);

    // Phase 0 keeps the reset config; later phases reprogram while idle.
    // Every third phase runs with no idling on either side.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain_results();
        program_regs(phase_cfg(phase));
      end
      calm = (phase % 3 == 2);
      run_random(PHASE_POLLS);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== touch_swipe_tap_level_control.f =====
hdl/tstl_pkg.sv
hdl/tstl_in_if.sv
hdl/tstl_out_if.sv
hdl/tstl_alu.sv
hdl/tstl_ctrl.sv
hdl/touch_swipe_tap_level_control.sv
tb/sv/touch_swipe_tap_level_control_tb.sv
